// ===== hdl/atan2t_pkg.sv =====
// shared types and constants for the fixed point atan2 turns unit
// no dependencies; imported by atan2t_div_stage and fixed_point_atan2_turns_unit
package atan2t_pkg;

  localparam int MAG_W = 32;
  localparam int Q_W   = 17;
  localparam int T_W   = 12;
  localparam int A_W   = 15;

  localparam logic [15:0]      ZERO_ANGLE   = 16'hC000;
  localparam logic [13:0]      OCTANT_BASE  = 14'h2000;
  localparam logic [T_W-1:0]   CURVE_COEF   = 12'hB20;
  localparam logic [Q_W-1:0]   FX_ONE       = 17'h10000;
  localparam logic [15:0]      QUARTER_TURN = 16'h4000;
  localparam logic [15:0]      HALF_TURN    = 16'h8000;

  typedef struct packed {
    logic zero;
    logic mirror;
    logic negate;
    logic swap;
  } fold_t;

endpackage

// ===== hdl/atan2t_div_stage.sv =====
// one restoring divide step of the ratio pipeline, one quotient bit per stage
// depends on atan2t_pkg
module atan2t_div_stage import atan2t_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_prev,
  input  fold_t            fold_prev,
  input  logic [MAG_W:0]   part_prev,
  input  logic [MAG_W-1:0] divisor_prev,
  input  logic [Q_W-1:0]   q_prev,
  output logic             valid,
  output fold_t            fold,
  output logic [MAG_W-1:0] rem,
  output logic [MAG_W-1:0] divisor,
  output logic [Q_W-1:0]   q
);

  logic [MAG_W:0] trial;
  logic           qbit;

  assign trial = part_prev - {1'b0, divisor_prev};
  assign qbit  = part_prev >= {1'b0, divisor_prev};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold    <= fold_prev;
      divisor <= divisor_prev;
      rem     <= qbit ? trial[MAG_W-1:0] : part_prev[MAG_W-1:0];
      q       <= {q_prev[Q_W-2:0], qbit};
    end
  end

endmodule

// ===== hdl/fixed_point_atan2_turns_unit.sv =====
// top level of the fixed point atan2 turns unit: fold, pipelined divide, curve, unfold
// depends on atan2t_pkg and atan2t_div_stage
//
// usage:
//   request channel: vec_valid / vec_stall with vec_x, vec_y (signed 16.16).
//   result channel: angle_valid / angle_stall with angle_turns (turns / 65536).
//   a request is taken at a rising edge with valid high and stall low.
//   one result per request, in request order.
//   pipeline: 22 register stages (fold, sort, 17 divide steps, two multiply
//   stages, unfold into the output register).
//   throughput: one request per cycle while angle_stall does not hold the pipeline;
//   each divide stage resolves one quotient bit with a 33-bit compare and subtract.
//   when angle_stall is high while a result is shown, the whole pipeline
//   holds and vec_stall is raised in the same cycle; nothing is dropped.
//   reset clears every valid bit; the pipeline is empty afterwards.
//   a zero vector yields 0xC000.
module fixed_point_atan2_turns_unit import atan2t_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        vec_valid,
  output logic        vec_stall,
  input  logic [31:0] vec_x,
  input  logic [31:0] vec_y,
  output logic        angle_valid,
  input  logic        angle_stall,
  output logic [15:0] angle_turns
);

  logic en;
  assign en        = !angle_valid || !angle_stall;
  assign vec_stall = !en;

  // fold into first quadrant
  logic             s0_valid;
  fold_t            s0_fold;
  logic [MAG_W-1:0] s0_ax, s0_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_fold.zero   <= (vec_x == '0) && (vec_y == '0);
      s0_fold.mirror <= vec_x[31];
      s0_fold.negate <= !vec_y[31] && (vec_y != '0);
      s0_fold.swap   <= 1'b0;
      s0_ax          <= vec_x[31] ? (32'd0 - vec_x) : vec_x;
      s0_ay          <= vec_y[31] ? (32'd0 - vec_y) : vec_y;
    end
  end

  // sort magnitudes
  logic             s1_valid;
  fold_t            s1_fold;
  logic [MAG_W-1:0] s1_small, s1_large;
  logic             s0_swap;

  assign s0_swap = s0_ay > s0_ax;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fold.zero   <= s0_fold.zero;
      s1_fold.mirror <= s0_fold.mirror;
      s1_fold.negate <= s0_fold.negate;
      s1_fold.swap   <= s0_swap;
      s1_small       <= s0_swap ? s0_ax : s0_ay;
      s1_large       <= s0_swap ? s0_ay : s0_ax;
    end
  end

  // divide pipeline
  logic             dv_valid   [Q_W];
  fold_t            dv_fold    [Q_W];
  logic [MAG_W-1:0] dv_rem     [Q_W];
  logic [MAG_W-1:0] dv_divisor [Q_W];
  logic [Q_W-1:0]   dv_q       [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    logic             v_prev;
    fold_t            f_prev;
    logic [MAG_W:0]   p_prev;
    logic [MAG_W-1:0] d_prev;
    logic [Q_W-1:0]   q_prev;

    if (i == 0) begin : g_first
      assign v_prev = s1_valid;
      assign f_prev = s1_fold;
      assign p_prev = {1'b0, s1_small};
      assign d_prev = s1_large;
      assign q_prev = '0;
    end else begin : g_next
      assign v_prev = dv_valid[i-1];
      assign f_prev = dv_fold[i-1];
      assign p_prev = {dv_rem[i-1], 1'b0};
      assign d_prev = dv_divisor[i-1];
      assign q_prev = dv_q[i-1];
    end

    atan2t_div_stage u_stage (
      .clk          (clk),
      .rst          (rst),
      .en           (en),
      .valid_prev   (v_prev),
      .fold_prev    (f_prev),
      .part_prev    (p_prev),
      .divisor_prev (d_prev),
      .q_prev       (q_prev),
      .valid        (dv_valid[i]),
      .fold         (dv_fold[i]),
      .rem          (dv_rem[i]),
      .divisor      (dv_divisor[i]),
      .q            (dv_q[i])
    );
  end

  // curve term t = coef * (1 - r)
  logic             st_valid;
  fold_t            st_fold;
  logic [Q_W-1:0]   st_r;
  logic [T_W-1:0]   st_t;
  logic [Q_W-1:0]   inv_r;
  logic [28:0]      t_prod;

  assign inv_r  = FX_ONE - dv_q[Q_W-1];
  assign t_prod = 29'(CURVE_COEF) * 29'(inv_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (en) begin
      st_valid <= dv_valid[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_fold <= dv_fold[Q_W-1];
      st_r    <= dv_q[Q_W-1];
      st_t    <= t_prod[16 +: T_W];
    end
  end

  // octant angle a = r * (base + t)
  logic             sa_valid;
  fold_t            sa_fold;
  logic [A_W-1:0]   sa_a;
  logic [30:0]      a_prod;

  assign a_prod = 31'(st_r) * 31'(OCTANT_BASE + 14'(st_t));

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_fold <= st_fold;
      sa_a    <= a_prod[16 +: A_W];
    end
  end

  // unfold and wrap
  logic [15:0] u_swap, u_mirror, u_negate;

  always_comb begin
    u_swap   = sa_fold.swap   ? (QUARTER_TURN - 16'(sa_a)) : 16'(sa_a);
    u_mirror = sa_fold.mirror ? (HALF_TURN - u_swap) : u_swap;
    u_negate = sa_fold.negate ? (16'd0 - u_mirror) : u_mirror;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (en) begin
      angle_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_turns <= sa_fold.zero ? ZERO_ANGLE : u_negate;
    end
  end

  // checks
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fold.zero) |-> (s1_large >= s1_small && s1_large != '0))
    else $error("magnitude sort broken");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    (dv_valid[Q_W-1] && !dv_fold[Q_W-1].zero) |-> (dv_q[Q_W-1] <= FX_ONE))
    else $error("ratio above one");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    vec_stall == (angle_valid && angle_stall))
    else $error("request stall does not follow result stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && angle_stall) |=> ($stable(sa_a) && $stable(sa_valid)))
    else $error("pipeline moved while stalled");

endmodule
